### hw/rtl/scrc_pkg.sv
// ----------------------------------------------------------------------------
// scrc_pkg
// Shared types and constants for the clip rectangle stack: field widths,
// command and error codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package scrc_pkg;

	// field widths
	localparam int COORD_W = 24;   // signed Q8.16 coordinates
	localparam int EDGE_W  = 18;   // running edges, Q1.17, inside [0, 2^17]
	localparam int EXT_W   = 26;   // entry edges 2*c +/- s, signed
	localparam int PX_W    = 15;   // pixel fields and target size
	localparam int ERR_W   = 2;

	localparam int STACK_DEPTH_DEF = 16;

	// full screen high edge, 1.0 in Q1.17
	localparam logic [EDGE_W-1:0] ONE_Q17 = EDGE_W'(131072);

	localparam logic [PX_W-1:0] TARGET_W_RST = PX_W'(1920);
	localparam logic [PX_W-1:0] TARGET_H_RST = PX_W'(1080);

	// command kinds
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	// configuration register indexes
	localparam logic CFG_TARGET_W = 1'b0;
	localparam logic CFG_TARGET_H = 1'b1;

	// one stored rectangle
	typedef struct packed {
		logic signed [COORD_W-1:0] size_y;
		logic signed [COORD_W-1:0] size_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_x;
	} geo_t;

	// running clip edges
	typedef struct packed {
		logic [EDGE_W-1:0] x_lo;
		logic [EDGE_W-1:0] x_hi;
		logic [EDGE_W-1:0] y_lo;
		logic [EDGE_W-1:0] y_hi;
	} edges_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE_RD,
		ST_BASE_LD,
		ST_FOLD,
		ST_SCALE,
		ST_DONE
	} state_t;

endpackage

### hw/rtl/scrc_fold.sv
// ----------------------------------------------------------------------------
// scrc_fold
// Intersects the running clip edges with one stack entry on both axes.
// Flags an empty overlap when max(lows) >= min(highs) on either axis.
// ----------------------------------------------------------------------------
module scrc_fold
	import scrc_pkg::*;
(
	input  edges_t cur,
	input  geo_t   geo,
	output edges_t nxt,
	output logic   empty
);

	logic signed [EXT_W-1:0] ex_lo, ex_hi, ey_lo, ey_hi;
	logic signed [EXT_W-1:0] cx_lo, cx_hi, cy_lo, cy_hi;
	logic signed [EXT_W-1:0] nx_lo, nx_hi, ny_lo, ny_hi;

	// entry edges: 2*center -/+ size
	always_comb begin
		ex_lo = $signed({geo.center_x[COORD_W-1], geo.center_x, 1'b0})
			- $signed({{2{geo.size_x[COORD_W-1]}}, geo.size_x});
		ex_hi = $signed({geo.center_x[COORD_W-1], geo.center_x, 1'b0})
			+ $signed({{2{geo.size_x[COORD_W-1]}}, geo.size_x});
		ey_lo = $signed({geo.center_y[COORD_W-1], geo.center_y, 1'b0})
			- $signed({{2{geo.size_y[COORD_W-1]}}, geo.size_y});
		ey_hi = $signed({geo.center_y[COORD_W-1], geo.center_y, 1'b0})
			+ $signed({{2{geo.size_y[COORD_W-1]}}, geo.size_y});
	end

	// running edges are non-negative
	assign cx_lo = $signed({{(EXT_W-EDGE_W){1'b0}}, cur.x_lo});
	assign cx_hi = $signed({{(EXT_W-EDGE_W){1'b0}}, cur.x_hi});
	assign cy_lo = $signed({{(EXT_W-EDGE_W){1'b0}}, cur.y_lo});
	assign cy_hi = $signed({{(EXT_W-EDGE_W){1'b0}}, cur.y_hi});

	// max of lows, min of highs
	assign nx_lo = (cx_lo > ex_lo) ? cx_lo : ex_lo;
	assign nx_hi = (cx_hi < ex_hi) ? cx_hi : ex_hi;
	assign ny_lo = (cy_lo > ey_lo) ? cy_lo : ey_lo;
	assign ny_hi = (cy_hi < ey_hi) ? cy_hi : ey_hi;

	assign empty = (nx_lo >= nx_hi) || (ny_lo >= ny_hi);

	// on a non-empty overlap the new edges stay inside the old ones
	assign nxt.x_lo = nx_lo[EDGE_W-1:0];
	assign nxt.x_hi = nx_hi[EDGE_W-1:0];
	assign nxt.y_lo = ny_lo[EDGE_W-1:0];
	assign nxt.y_hi = ny_hi[EDGE_W-1:0];

endmodule

### hw/rtl/scissor_clip_rect_stack_top.sv
// ----------------------------------------------------------------------------
// scissor_clip_rect_stack_top
// Clip rectangle stack: push/pop beats update the stack, then the active run
// of entries is intersected with the screen and scaled to pixels.
// ----------------------------------------------------------------------------
// Each accepted beat first updates the stack; a pop that leaves entries then
// re-reads the new top's run base (ST_BASE_RD, ST_BASE_LD). The n active
// entries (from the topmost non-additive entry up to the top, one memory
// read per cycle) are folded, the four pixel fields are scaled in turn
// through the one shared 18x15 multiplier and ST_DONE hands the result to
// the output register. s_tready is low while a beat is in work. The result
// register lets the next beat in while a result still waits on m_tready;
// the result of that next beat then holds in ST_DONE until the register
// is free.
// ----------------------------------------------------------------------------
module scissor_clip_rect_stack_top
	import scrc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,

	input  logic            cfg_we,
	input  logic            cfg_addr,
	input  logic [PX_W-1:0] cfg_wdata,

	input  logic            s_tvalid,
	output logic            s_tready,
	// center_x[23:0], center_y[47:24], rect_width[71:48], rect_height[95:72]
	input  logic [95:0]     s_tdata,
	// kind[0], is_additive[1]
	input  logic [1:0]      s_tuser,

	output logic            m_tvalid,
	input  logic            m_tready,
	// clip_x_px[14:0], clip_y_px[29:15], clip_w_px[44:30], clip_h_px[59:45],
	// stack_error[61:60], zero fill[63:62]
	output logic [63:0]     m_tdata
);

	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
	localparam int PROD_W = EDGE_W + PX_W;

	// configuration
	logic [PX_W-1:0] target_w_q, target_h_q;

	// stack memory: geometry and base index of each entry's run
	geo_t             mem_geo_q  [STACK_DEPTH];
	logic [IDX_W-1:0] mem_base_q [STACK_DEPTH];
	geo_t             rd_geo_q;
	logic [IDX_W-1:0] rd_base_q;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] top_base_q;
	logic [CNT_W-1:0] fidx_q;
	logic             pend_q;
	logic             empty_q;
	edges_t           edges_q;
	logic [ERR_W-1:0] err_q;
	logic [1:0]       sc_q;
	logic [PX_W-1:0]  res_q [4];
	logic             m_tvalid_q;
	logic [63:0]      m_tdata_q;

	// decode of the incoming beat
	logic             accept, is_push, push_ok, pop_ok;
	logic [IDX_W-1:0] new_base;
	geo_t             in_geo;
	logic [ERR_W-1:0] in_err;

	// sequencer controls
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             issue;
	logic             out_free;
	logic             out_load;

	// fold unit
	edges_t           fold_nxt;
	logic             fold_empty;

	// shared scaling multiplier
	logic [EDGE_W-1:0] mul_a;
	logic [PX_W-1:0]   mul_b;
	logic [PROD_W-1:0] prod;

	// ------------------------------------------------------------------
	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_w_q <= TARGET_W_RST;
			target_h_q <= TARGET_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_TARGET_W: target_w_q <= cfg_wdata;
				CFG_TARGET_H: target_h_q <= cfg_wdata;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// beat decode
	assign accept  = s_tvalid && s_tready;
	assign is_push = (s_tuser[0] == KIND_PUSH);
	assign push_ok = is_push && (count_q != DEPTH_C);
	assign pop_ok  = !is_push && (count_q != '0);

	assign in_geo.center_x = s_tdata[23:0];
	assign in_geo.center_y = s_tdata[47:24];
	assign in_geo.size_x   = s_tdata[71:48];
	assign in_geo.size_y   = s_tdata[95:72];

	// an additive entry inherits the run base of the entry below
	assign new_base = (s_tuser[1] && (count_q != '0)) ? top_base_q
		: count_q[IDX_W-1:0];

	always_comb begin
		if (is_push && !push_ok) begin
			in_err = ERR_FULL;
		end else if (!is_push && !pop_ok) begin
			in_err = ERR_EMPTY;
		end else begin
			in_err = ERR_NONE;
		end
	end

	// ------------------------------------------------------------------
	// sequencer outputs
	assign issue    = (fidx_q < count_q);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = fidx_q[IDX_W-1:0];
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_BASE_RD: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(count_q - CNT_W'(1));
			end
			ST_FOLD: begin
				rd_en = issue;
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (pop_ok && (count_q > CNT_W'(1))) ? ST_BASE_RD : ST_FOLD;
				end
			end
			ST_BASE_RD: state_d = ST_BASE_LD;
			ST_BASE_LD: state_d = ST_FOLD;
			ST_FOLD: begin
				if (!issue && !pend_q) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (sc_q == 2'd3) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// stack memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (accept && push_ok) begin
			mem_geo_q[count_q[IDX_W-1:0]]  <= in_geo;
			mem_base_q[count_q[IDX_W-1:0]] <= new_base;
		end
		if (rd_en) begin
			rd_geo_q  <= mem_geo_q[rd_addr];
			rd_base_q <= mem_base_q[rd_addr];
		end
	end

	// ------------------------------------------------------------------
	// stack pointer and run base of the top entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			top_base_q <= '0;
		end else if (accept) begin
			if (push_ok) begin
				count_q    <= count_q + CNT_W'(1);
				top_base_q <= new_base;
			end else if (pop_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end else if (state_q == ST_BASE_LD) begin
			top_base_q <= rd_base_q;
		end
	end

	// ------------------------------------------------------------------
	// fold loop: read entry fidx, fold the one read in the cycle before
	scrc_fold u_fold (
		.cur   (edges_q),
		.geo   (rd_geo_q),
		.nxt   (fold_nxt),
		.empty (fold_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q  <= '0;
			pend_q  <= 1'b0;
			empty_q <= 1'b0;
			err_q   <= ERR_NONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fidx_q  <= CNT_W'(push_ok ? new_base : top_base_q);
						pend_q  <= 1'b0;
						empty_q <= 1'b0;
						err_q   <= in_err;
					end
				end
				ST_BASE_LD: begin
					fidx_q <= CNT_W'(rd_base_q);
				end
				ST_FOLD: begin
					pend_q <= issue;
					if (issue) begin
						fidx_q <= fidx_q + CNT_W'(1);
					end
					if (pend_q && !empty_q && fold_empty) begin
						empty_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// running edges start at the full screen
	always_ff @(posedge clk) begin
		if (accept) begin
			edges_q.x_lo <= '0;
			edges_q.x_hi <= ONE_Q17;
			edges_q.y_lo <= '0;
			edges_q.y_hi <= ONE_Q17;
		end else if (state_q == ST_FOLD && pend_q && !empty_q && !fold_empty) begin
			edges_q <= fold_nxt;
		end
	end

	// ------------------------------------------------------------------
	// pixel scaling: one product per cycle, (v * size) >> 17
	always_comb begin
		case (sc_q)
			2'd0: begin
				mul_a = edges_q.x_lo;
				mul_b = target_w_q;
			end
			2'd1: begin
				mul_a = edges_q.y_lo;
				mul_b = target_h_q;
			end
			2'd2: begin
				mul_a = edges_q.x_hi - edges_q.x_lo;
				mul_b = target_w_q;
			end
			default: begin
				mul_a = edges_q.y_hi - edges_q.y_lo;
				mul_b = target_h_q;
			end
		endcase
		// an empty overlap gives all zeros
		if (empty_q) begin
			mul_a = '0;
		end
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= '0;
		end else if (state_q == ST_SCALE) begin
			sc_q <= sc_q + 2'd1;
		end else begin
			sc_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) begin
			res_q[sc_q] <= prod[17 +: PX_W];
		end
	end

	// ------------------------------------------------------------------
	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, err_q, res_q[3], res_q[2], res_q[1], res_q[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count above depth");

	a_base_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q != '0) |-> (CNT_W'(top_base_q) < count_q))
		else $error("run base of top entry not below count");

	a_fold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> (fidx_q <= count_q))
		else $error("fold index past top of stack");

	a_full_error: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_push && count_q == DEPTH_C) |=> (err_q == ERR_FULL && $stable(count_q)))
		else $error("push on full stack not flagged or stack changed");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a beat not yet taken");

endmodule

### verif/scissor_clip_rect_stack_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scissor_clip_rect_stack_top_test
// Self-checking bench for the clip rectangle stack. A queue-fed driver sends
// push and pop beats. A predictor keeps its own stack and folds the active run
// of rectangles in exact integer edges to get the expected pixel clip. A
// monitor checks every result beat field by field. The target size is changed
// between phases, with the extremes among the settings.
// ----------------------------------------------------------------------------
module scissor_clip_rect_stack_top_test;
	import scrc_pkg::*;

	localparam int DEPTH   = STACK_DEPTH_DEF;
	localparam int Q16_ONE = 65536;
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam int PRINT_CAP = 100;

	// common Q8.16 coordinates
	localparam logic signed [COORD_W-1:0] C_ONE      = COORD_W'(Q16_ONE);
	localparam logic signed [COORD_W-1:0] C_HALF     = COORD_W'(Q16_ONE / 2);
	localparam logic signed [COORD_W-1:0] C_QUARTER  = COORD_W'(Q16_ONE / 4);
	localparam logic signed [COORD_W-1:0] C_3QUARTER = COORD_W'(3 * Q16_ONE / 4);
	localparam logic signed [COORD_W-1:0] C_EIGHTH   = COORD_W'(Q16_ONE / 8);
	localparam logic signed [COORD_W-1:0] C_5EIGHTH  = COORD_W'(5 * Q16_ONE / 8);
	localparam logic signed [COORD_W-1:0] C_NEG_LSB  = COORD_W'(-1);

	typedef struct {
		logic                      kind;
		logic                      additive;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
	} rect_cmd_t;

	typedef struct {
		logic [PX_W-1:0]  x;
		logic [PX_W-1:0]  y;
		logic [PX_W-1:0]  w;
		logic [PX_W-1:0]  h;
		logic [ERR_W-1:0] err;
	} clip_px_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cfg_we    = 1'b0;
	logic            cfg_addr  = CFG_TARGET_W;
	logic [PX_W-1:0] cfg_wdata = '0;
	logic            s_tvalid  = 1'b0;
	logic            s_tready;
	// center_x[23:0], center_y[47:24], rect_width[71:48], rect_height[95:72]
	logic [95:0]     s_tdata   = '0;
	// kind[0], is_additive[1]
	logic [1:0]      s_tuser   = '0;
	logic            m_tvalid;
	logic            m_tready  = 1'b0;
	// clip_x_px[14:0], clip_y_px[29:15], clip_w_px[44:30], clip_h_px[59:45],
	// stack_error[61:60]
	logic [63:0]     m_tdata;

	scissor_clip_rect_stack_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	// predictor state: shadow stack and target size
	logic signed [COORD_W-1:0] stk_cx  [DEPTH];
	logic signed [COORD_W-1:0] stk_cy  [DEPTH];
	logic signed [COORD_W-1:0] stk_sx  [DEPTH];
	logic signed [COORD_W-1:0] stk_sy  [DEPTH];
	logic                      stk_add [DEPTH];
	int                        stk_count = 0;
	logic [PX_W-1:0]           tgt_w = TARGET_W_RST;
	logic [PX_W-1:0]           tgt_h = TARGET_H_RST;

	rect_cmd_t cmd_q[$];
	clip_px_t  clip_q[$];
	rect_cmd_t on_bus;

	int beats_in     = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int pushes       = 0;
	int pops         = 0;
	int full_hits    = 0;
	int empty_hits   = 0;
	int gen_depth    = 0;
	bit climbing     = 1'b1;

	// narrow running edges [lo,hi] by one entry on one axis; 0 if empty
	function automatic bit narrow_axis(inout longint lo, inout longint hi,
		input logic signed [COORD_W-1:0] c, input logic signed [COORD_W-1:0] s);
		longint e_lo, e_hi, n_lo, n_hi;
		e_lo = 2 * longint'(c) - longint'(s);
		e_hi = 2 * longint'(c) + longint'(s);
		n_lo = (lo > e_lo) ? lo : e_lo;
		n_hi = (hi < e_hi) ? hi : e_hi;
		if (n_lo >= n_hi)
			return 1'b0;
		lo = n_lo;
		hi = n_hi;
		return 1'b1;
	endfunction

	function automatic logic [PX_W-1:0] scale_px(longint v, logic [PX_W-1:0] size);
		longint p;
		p = (v * longint'(size)) >> 17;
		return p[PX_W-1:0];
	endfunction

	// clip of the current shadow stack, error field left at none
	function automatic clip_px_t clip_of_stack();
		longint   x_lo, x_hi, y_lo, y_hi;
		int       base;
		bit       collapsed;
		clip_px_t r;
		x_lo = 0;
		x_hi = 2 * Q16_ONE;
		y_lo = 0;
		y_hi = 2 * Q16_ONE;
		base = 0;
		collapsed = 1'b0;
		// fold starts at the topmost entry that restarts from the screen
		for (int i = stk_count - 1; i >= 0; i--) begin
			if (!stk_add[i]) begin
				base = i;
				break;
			end
		end
		for (int i = base; i < stk_count; i++) begin
			if (!narrow_axis(x_lo, x_hi, stk_cx[i], stk_sx[i]) ||
				!narrow_axis(y_lo, y_hi, stk_cy[i], stk_sy[i])) begin
				collapsed = 1'b1;
				break;
			end
		end
		if (collapsed) begin
			r.x = '0;
			r.y = '0;
			r.w = '0;
			r.h = '0;
		end else begin
			r.x = scale_px(x_lo, tgt_w);
			r.y = scale_px(y_lo, tgt_h);
			r.w = scale_px(x_hi - x_lo, tgt_w);
			r.h = scale_px(y_hi - y_lo, tgt_h);
		end
		r.err = ERR_NONE;
		return r;
	endfunction

	// update the shadow stack with one command and return its clip
	function automatic clip_px_t apply_cmd(rect_cmd_t c);
		logic [ERR_W-1:0] err;
		clip_px_t         r;
		err = ERR_NONE;
		if (c.kind == KIND_PUSH) begin
			if (stk_count >= DEPTH) begin
				err = ERR_FULL;
			end else begin
				stk_cx[stk_count]  = c.cx;
				stk_cy[stk_count]  = c.cy;
				stk_sx[stk_count]  = c.sx;
				stk_sy[stk_count]  = c.sy;
				stk_add[stk_count] = c.additive;
				stk_count++;
			end
		end else if (stk_count == 0) begin
			err = ERR_EMPTY;
		end else begin
			stk_count--;
		end
		r = clip_of_stack();
		r.err = err;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s got %0d want %0d",
				results_seen, name, got, want));
	endtask

	// driver: holds a beat until accepted, predicts on acceptance
	always @(posedge clk) begin : drive_proc
		clip_px_t exp_clip;
		bit       quiet;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				exp_clip = apply_cmd(on_bus);
				clip_q.insert(clip_q.size(), exp_clip);
				beats_in++;
				if (on_bus.kind == KIND_PUSH)
					pushes++;
				else
					pops++;
				if (exp_clip.err == ERR_FULL)
					full_hits++;
				if (exp_clip.err == ERR_EMPTY)
					empty_hits++;
			end
			quiet = (beats_in >= 600 && beats_in < 800);
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
					on_bus = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {on_bus.sy, on_bus.sx, on_bus.cy, on_bus.cx};
					s_tuser  <= {on_bus.additive, on_bus.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks result beats and drives ready with one long hold-off
	int rx_hold_left = 0;
	bit rx_hold_done = 1'b0;

	always @(posedge clk) begin : monitor_proc
		clip_px_t want;
		bit       quiet;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (clip_q.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected, data %h",
						results_seen, m_tdata));
				end else begin
					want = clip_q.pop_front();
					check_field("clip_x_px", m_tdata[14:0], want.x);
					check_field("clip_y_px", m_tdata[29:15], want.y);
					check_field("clip_w_px", m_tdata[44:30], want.w);
					check_field("clip_h_px", m_tdata[59:45], want.h);
					check_field("stack_error", m_tdata[61:60], want.err);
				end
			end
			quiet = (results_seen >= 600 && results_seen < 800);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (!rx_hold_done && results_seen >= 250) begin
				// long back-pressure so the block fills and stalls its input
				rx_hold_done = 1'b1;
				rx_hold_left = 400;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 10);
			end
		end
	end

	task automatic queue_cmd(logic kind, logic additive,
		logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
		logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy);
		rect_cmd_t c;
		c.kind     = kind;
		c.additive = additive;
		c.cx       = cx;
		c.cy       = cy;
		c.sx       = sx;
		c.sy       = sy;
		cmd_q.insert(cmd_q.size(), c);
		if (kind == KIND_PUSH && gen_depth < DEPTH)
			gen_depth++;
		else if (kind == KIND_POP && gen_depth > 0)
			gen_depth--;
	endtask

	function automatic logic signed [COORD_W-1:0] corner_coord();
		case ($urandom_range(7))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3: return COORD_W'(1);
			4: return C_NEG_LSB;
			5: return C_HALF;
			6: return C_ONE;
			default: return COORD_W'(2 * Q16_ONE);
		endcase
	endfunction

	// random walk that climbs to full and drains to empty, mostly sane rects
	task automatic queue_random(int n);
		logic                      kind;
		logic signed [COORD_W-1:0] cx, cy, sx, sy;
		int                        shape;
		for (int k = 0; k < n; k++) begin
			if (gen_depth == DEPTH && $urandom_range(3) == 0)
				climbing = 1'b0;
			else if (gen_depth == 0 && $urandom_range(3) == 0)
				climbing = 1'b1;
			else if ($urandom_range(29) == 0)
				climbing = !climbing;
			if (climbing)
				kind = ($urandom_range(99) < 80) ? KIND_PUSH : KIND_POP;
			else
				kind = ($urandom_range(99) < 80) ? KIND_POP : KIND_PUSH;
			shape = $urandom_range(99);
			if (shape < 70) begin
				cx = COORD_W'($urandom_range(Q16_ONE));
				cy = COORD_W'($urandom_range(Q16_ONE));
				sx = COORD_W'($urandom_range(1, Q16_ONE));
				sy = COORD_W'($urandom_range(1, Q16_ONE));
			end else if (shape < 85) begin
				cx = COORD_W'($urandom);
				cy = COORD_W'($urandom);
				sx = COORD_W'($urandom);
				sy = COORD_W'($urandom);
			end else begin
				cx = corner_coord();
				cy = corner_coord();
				sx = corner_coord();
				sy = corner_coord();
			end
			queue_cmd(kind, $urandom_range(99) < 65, cx, cy, sx, sy);
		end
	endtask

	task automatic write_reg(logic addr, logic [PX_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (addr == CFG_TARGET_W)
			tgt_w = value;
		else
			tgt_h = value;
	endtask

	// sender pause: wait until every beat is sent and every clip has come back
	task automatic wait_idle();
		while (cmd_q.size() != 0 || s_tvalid || clip_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_target(logic [PX_W-1:0] w, logic [PX_W-1:0] h);
		wait_idle();
		write_reg(CFG_TARGET_W, w);
		write_reg(CFG_TARGET_H, h);
	endtask

	initial begin : stimulus_proc
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pop, screen, nesting, extremes, degenerate sizes
		queue_cmd(KIND_POP,  1'b1, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
		queue_cmd(KIND_PUSH, 1'b0, C_HALF, C_HALF, C_ONE, C_ONE);
		queue_cmd(KIND_PUSH, 1'b1, C_HALF, C_HALF, C_HALF, C_HALF);
		// huge rect covering the screen leaves the clip unchanged
		queue_cmd(KIND_PUSH, 1'b1, '0, '0, COORD_MAX, COORD_MAX);
		queue_cmd(KIND_POP,  1'b0, '0, '0, '0, '0);
		// far right / far left rects miss the screen
		queue_cmd(KIND_PUSH, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		queue_cmd(KIND_POP,  1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		queue_cmd(KIND_PUSH, 1'b1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
		queue_cmd(KIND_POP,  1'b0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		// zero and negative sizes
		queue_cmd(KIND_PUSH, 1'b1, C_HALF, C_HALF, '0, '0);
		queue_cmd(KIND_POP,  1'b1, '0, '0, '0, '0);
		queue_cmd(KIND_PUSH, 1'b1, C_HALF, C_HALF, COORD_MIN, C_NEG_LSB);
		queue_cmd(KIND_POP,  1'b1, '0, '0, '0, '0);
		// non-additive restart, then disjoint in y only
		queue_cmd(KIND_PUSH, 1'b0, C_QUARTER, C_3QUARTER, C_QUARTER, C_QUARTER);
		queue_cmd(KIND_PUSH, 1'b1, C_QUARTER, C_EIGHTH, C_ONE, C_EIGHTH);
		queue_cmd(KIND_POP,  1'b1, '0, '0, '0, '0);
		// entry whose low x edge meets the running high edge exactly
		queue_cmd(KIND_PUSH, 1'b1, C_5EIGHTH, C_HALF, C_HALF, C_ONE);
		queue_cmd(KIND_POP,  1'b1, '0, '0, '0, '0);
		// drain to empty, then pop again
		repeat (3) queue_cmd(KIND_POP, 1'b0, '0, '0, '0, '0);
		queue_cmd(KIND_POP,  1'b0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);

		queue_random(340);
		set_target(15'd1, 15'd16384);
		queue_random(300);
		set_target(15'd16384, 15'd1);
		queue_random(300);
		// zero width target and the widest value the register holds
		set_target('0, {PX_W{1'b1}});
		queue_random(150);
		set_target(PX_W'($urandom_range(1, 16384)), PX_W'($urandom_range(1, 16384)));
		queue_random(300);

		wait_idle();
		repeat (30) @(posedge clk);
		$display("Checked %0d clips from %0d beats (%0d pushes, %0d pops) over five targets,",
			results_seen, beats_in, pushes, pops);
		$display("with %0d full-stack pushes and %0d empty-stack pops.", full_hits, empty_hits);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin : watchdog_proc
		#2000000;
		$display("Timeout: %0d of %0d clips still missing", clip_q.size() + cmd_q.size(),
			beats_in + cmd_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
